@@ rtl/entry_exit_latency_table_unit_macros.svh @@
// Assertion macros shared by the latency table RTL.
// Needs signals named clk and arst_n in the module that uses them.
`ifndef ENTRY_EXIT_LATENCY_TABLE_UNIT_MACROS_SVH
`define ENTRY_EXIT_LATENCY_TABLE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define EELT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);
`define EELT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);
`else
`define EELT_ASSERT(lbl, prop, msg)
`define EELT_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

@@ rtl/eelt_pkg.sv @@
// Shared types and constants of the entry/exit latency table.
// No dependencies; used by the interfaces and all modules but the RAM.
`timescale 1ns / 1ps
package eelt_pkg;

	localparam int KEY_W  = 64;
	localparam int TIME_W = 64;
	localparam int HALF_W = 32;

	// Event command codes.
	typedef enum logic {
		CMD_ENTRY = 1'b0,
		CMD_EXIT  = 1'b1
	} cmd_t;

	// Operations requested from the key table for one word.
	typedef struct packed {
		logic insert;
		logic release_slot;
	} cam_op_t;

	// Lookup status returned by the key table.
	typedef struct packed {
		logic hit;
		logic full;
	} cam_stat_t;

endpackage

@@ rtl/eelt_in_if.sv @@
// Event channel: valid/ready handshake with command, key and timestamp.
// Depends on eelt_pkg.
`timescale 1ns / 1ps
interface eelt_in_if;
	import eelt_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [KEY_W-1:0]  task_key;
	logic [TIME_W-1:0] event_time;

	modport source (output valid, output command, output task_key, output event_time,
		input ready);
	modport sink (input valid, input command, input task_key, input event_time,
		output ready);
endinterface

@@ rtl/eelt_out_if.sv @@
// Result channel: valid/ready handshake with key halves and duration.
// Depends on eelt_pkg.
`timescale 1ns / 1ps
interface eelt_out_if;
	import eelt_pkg::*;

	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] key_upper;
	logic [HALF_W-1:0] key_lower;
	logic [TIME_W-1:0] duration;

	modport source (output valid, output key_upper, output key_lower, output duration,
		input ready);
	modport sink (input valid, input key_upper, input key_lower, input duration,
		output ready);
endinterface

@@ rtl/eelt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module eelt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds while re is low.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ rtl/eelt_cam.sv @@
// Associative key table: valid bits and keys in flops, parallel compare,
// lowest free slot search. Depends on eelt_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "entry_exit_latency_table_unit_macros.svh"
module eelt_cam #(
	parameter int SLOTS = 32,
	parameter int IDX_W = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [eelt_pkg::KEY_W-1:0] lookup_key,
	input  eelt_pkg::cam_op_t         op,
	output eelt_pkg::cam_stat_t       stat,
	output logic [IDX_W-1:0]          hit_idx,
	output logic [IDX_W-1:0]          free_idx
);
	import eelt_pkg::*;

	logic [SLOTS-1:0] valid_q;
	logic [KEY_W-1:0] key_q [SLOTS];
	logic [SLOTS-1:0] match;

	// Compare the lookup key against every valid slot.
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match[i] = valid_q[i] && (key_q[i] == lookup_key);
		end
	end

	// Encode the matching slot; at most one slot can match.
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	// Lowest-numbered free slot.
	always_comb begin
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign stat.hit  = |match;
	assign stat.full = &valid_q;

	// Valid bits clear at reset; insert claims the free slot, release frees the hit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (op.insert) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (op.release_slot) begin
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

	// Key storage needs no reset; it is only read where valid.
	always_ff @(posedge clk) begin
		if (op.insert) begin
			key_q[free_idx] <= lookup_key;
		end
	end

	`EELT_ASSERT(a_match_unique, $onehot0(match), "key table holds a duplicate key")
	`EELT_ASSERT_NEVER(a_insert_legal, op.insert && (stat.hit || stat.full),
		"insert into a full table or of a present key")
	`EELT_ASSERT_NEVER(a_release_legal, op.release_slot && !stat.hit,
		"release without a matching slot")
	`EELT_ASSERT(a_insert_sets, op.insert |=> $countones(valid_q) == $countones($past(valid_q)) + 1,
		"insert did not claim exactly one slot")
endmodule

@@ rtl/entry_exit_latency_table_unit.sv @@
// Entry/exit latency table. For an exit word, the table lookup and start-time read
// are done from the input register, the key and start time move into stage 2, and
// the subtract goes into the output register.
// Throughput: one event word per cycle while the output is not stalled; the lookup and
// slot update are done together against the input register. Reset clears all valid bits at
// once and needs no sweep; keys and start times are left unreset.
`timescale 1ns / 1ps
`include "entry_exit_latency_table_unit_macros.svh"
module entry_exit_latency_table_unit #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	eelt_in_if.sink           events,
	eelt_out_if.source        results
);
	import eelt_pkg::*;

	localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	// Stage 1: registered event word.
	logic              valid_s1;
	logic              cmd_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [TIME_W-1:0] time_s1;

	// Stage 2: lookup outcome, start time arrives from the RAM.
	logic              valid_s2;
	logic              emit_s2;
	logic [KEY_W-1:0]  key_s2;
	logic [TIME_W-1:0] time_s2;
	logic [TIME_W-1:0] start_s2;

	// Output register.
	logic              out_valid_q;
	logic [HALF_W-1:0] key_upper_q;
	logic [HALF_W-1:0] key_lower_q;
	logic [TIME_W-1:0] duration_q;

	cam_op_t           cam_op;
	cam_stat_t         cam_stat;
	logic [IDX_W-1:0]  hit_idx;
	logic [IDX_W-1:0]  free_idx;
	logic              s2_free;
	logic              s1_adv;
	logic              is_exit;

	// Flow control: stage 2 may move unless it holds a result the output cannot take.
	assign s2_free       = !valid_s2 || !emit_s2 || !out_valid_q || results.ready;
	assign s1_adv        = valid_s1 && s2_free;
	assign events.ready  = !valid_s1 || s2_free;
	assign is_exit       = (cmd_s1 == CMD_EXIT);

	// Table operation for the word in stage 1.
	assign cam_op.insert       = s1_adv && !is_exit && !cam_stat.hit && !cam_stat.full;
	assign cam_op.release_slot = s1_adv && is_exit && cam_stat.hit;

	eelt_cam #(
		.SLOTS (TABLE_SLOTS),
		.IDX_W (IDX_W)
	) u_cam (
		.clk        (clk),
		.arst_n     (arst_n),
		.lookup_key (key_s1),
		.op         (cam_op),
		.stat       (cam_stat),
		.hit_idx    (hit_idx),
		.free_idx   (free_idx)
	);

	// Start times: written on insert, read on an exit hit.
	eelt_ram #(
		.WIDTH (TIME_W),
		.DEPTH (TABLE_SLOTS)
	) u_start_ram (
		.clk   (clk),
		.we    (cam_op.insert),
		.waddr (free_idx),
		.wdata (time_s1),
		.re    (cam_op.release_slot),
		.raddr (hit_idx),
		.rdata (start_s2)
	);

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (events.valid && events.ready) begin
			cmd_s1  <= events.command;
			key_s1  <= events.task_key;
			time_s1 <= events.event_time;
		end
	end

	// Stage 2 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
			emit_s2  <= cam_op.release_slot;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			key_s2  <= key_s1;
			time_s2 <= time_s1;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s2 && emit_s2 && s2_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: duration wraps modulo 2^64.
	always_ff @(posedge clk) begin
		if (valid_s2 && emit_s2 && s2_free) begin
			key_upper_q <= key_s2[KEY_W-1:HALF_W];
			key_lower_q <= key_s2[HALF_W-1:0];
			duration_q  <= time_s2 - start_s2;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.key_upper = key_upper_q;
	assign results.key_lower = key_lower_q;
	assign results.duration  = duration_q;

	`EELT_ASSERT(a_s1_to_s2, s1_adv |=> valid_s2, "stage 1 word did not reach stage 2")
	`EELT_ASSERT(a_s2_to_out, (valid_s2 && emit_s2 && s2_free) |=> out_valid_q,
		"result did not reach the output register")
	`EELT_ASSERT(a_s1_hold, (valid_s1 && !s2_free) |=> (valid_s1 && $stable(key_s1)),
		"stalled stage 1 word was lost")
	`EELT_ASSERT_NEVER(a_emit_exit_only, cam_op.release_slot && cam_op.insert,
		"one word both inserted and released")
endmodule

@@ tb/tb_entry_exit_latency_table_unit.sv @@
// Self-checking testbench for the entry/exit latency table: random event words in, latencies out.
// Depends on eelt_pkg, eelt_in_if, eelt_out_if and entry_exit_latency_table_unit.
`timescale 1ns / 1ps
module tb_entry_exit_latency_table_unit;
	import eelt_pkg::*;

	localparam int SLOTS     = 32;
	localparam int POOL_KEYS = 40;
	localparam int PHASES    = 8;
	localparam int PHASE_LEN = 180;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// One event word waiting to be sent, with the idle time that comes before it.
	typedef struct {
		cmd_t              command;
		logic [KEY_W-1:0]  task_key;
		logic [TIME_W-1:0] event_time;
		int                gap_before;
		bit                wait_drain;
	} event_word_t;

	// One latency record as the block should report it.
	typedef struct {
		logic [HALF_W-1:0] key_upper;
		logic [HALF_W-1:0] key_lower;
		logic [TIME_W-1:0] duration;
	} latency_rec_t;

	logic clk;
	logic arst_n;

	eelt_in_if  ev_if ();
	eelt_out_if res_if ();

	entry_exit_latency_table_unit #(
		.TABLE_SLOTS(SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (ev_if),
		.results (res_if)
	);

	event_word_t       pending_events[$];
	latency_rec_t      expected_latencies[$];
	event_word_t       cur_word;
	int                idle_left;
	int                stall_left;
	int                mon_cycles;
	int                fail_count;

	// Shadow copy of the open-transaction table.
	bit                open_valid[SLOTS];
	logic [KEY_W-1:0]  open_key[SLOTS];
	logic [TIME_W-1:0] open_start[SLOTS];

	int                n_events;
	int                n_stored;
	int                n_dup;
	int                n_full;
	int                n_miss;
	int                n_checked;

	logic [TIME_W-1:0] clock_ns;
	logic [KEY_W-1:0]  key_pool[POOL_KEYS];

	// Free-running clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mostly short idle stretches, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(30, 80);
	endfunction

	// Applies one accepted event word to the shadow table and queues its latency, if any.
	function automatic void predict_event(input event_word_t w);
		int i;
		int hit;
		int free_slot;
		latency_rec_t rec;
		hit = -1;
		free_slot = -1;
		for (i = SLOTS - 1; i >= 0; i--) begin
			if (open_valid[i] && open_key[i] == w.task_key)
				hit = i;
			if (!open_valid[i])
				free_slot = i;
		end
		n_events++;
		if (w.command == CMD_ENTRY) begin
			if (hit >= 0) begin
				n_dup++;
			end else if (free_slot < 0) begin
				n_full++;
			end else begin
				open_valid[free_slot] = 1'b1;
				open_key[free_slot] = w.task_key;
				open_start[free_slot] = w.event_time;
				n_stored++;
			end
		end else if (hit < 0) begin
			n_miss++;
		end else begin
			open_valid[hit] = 1'b0;
			rec.key_upper = w.task_key[63:32];
			rec.key_lower = w.task_key[31:0];
			rec.duration = w.event_time - open_start[hit];
			expected_latencies.push_back(rec);
		end
	endfunction

	// Timestamps mostly march forward; some jump anywhere or hit the extremes.
	function automatic logic [TIME_W-1:0] next_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) begin
			clock_ns = clock_ns + $urandom_range(1, 5000);
			return clock_ns;
		end
		if (r < 94)
			return {$urandom, $urandom};
		if (r < 96)
			return '0;
		if (r < 98)
			return ALL_ONES;
		return clock_ns - 1;
	endfunction

	task automatic add_word(input cmd_t c, input logic [KEY_W-1:0] k,
			input logic [TIME_W-1:0] t, input int gap, input bit drain);
		event_word_t w;
		w.command = c;
		w.task_key = k;
		w.event_time = t;
		w.gap_before = gap;
		w.wait_drain = drain;
		pending_events.push_back(w);
	endtask

	// New key pool: random keys plus near twins that differ in one bit or keep only one half.
	task automatic refill_pool();
		int i;
		for (i = 0; i < POOL_KEYS; i++)
			key_pool[i] = {$urandom, $urandom};
		key_pool[1] = key_pool[0] ^ 64'h8000_0000_0000_0000;
		key_pool[2] = key_pool[0] ^ 64'h0000_0001_0000_0000;
		key_pool[3] = key_pool[0] ^ 64'h0000_0000_0000_0001;
		key_pool[4] = {key_pool[0][63:32], 32'h0};
		key_pool[5] = {32'h0, key_pool[0][31:0]};
	endtask

	// Event driver: sends the queued words, with idle gaps and drain pauses.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_if.valid <= 1'b0;
			ev_if.command <= CMD_ENTRY;
			ev_if.task_key <= '0;
			ev_if.event_time <= '0;
			idle_left = 0;
		end else begin
			if (ev_if.valid && ev_if.ready)
				predict_event(cur_word);
			if (!ev_if.valid || ev_if.ready) begin
				if (idle_left > 0) begin
					idle_left--;
					ev_if.valid <= 1'b0;
				end else if (pending_events.size() == 0 ||
						(pending_events[0].wait_drain && expected_latencies.size() != 0)) begin
					ev_if.valid <= 1'b0;
				end else begin
					cur_word = pending_events.pop_front();
					ev_if.valid <= 1'b1;
					ev_if.command <= cur_word.command;
					ev_if.task_key <= cur_word.task_key;
					ev_if.event_time <= cur_word.event_time;
					if (pending_events.size() != 0)
						idle_left = pending_events[0].gap_before;
				end
			end
		end
	end

	// Result monitor: checks every latency word and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		latency_rec_t exp_rec;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			stall_left = 0;
			mon_cycles = 0;
		end else begin
			mon_cycles++;
			if (res_if.valid && res_if.ready) begin
				if (expected_latencies.size() == 0) begin
					$error("unexpected result word: key %h_%h duration %h",
						res_if.key_upper, res_if.key_lower, res_if.duration);
					fail_count++;
				end else begin
					exp_rec = expected_latencies.pop_front();
					n_checked++;
					if (res_if.key_upper !== exp_rec.key_upper) begin
						$error("key_upper: expected %h, actual %h",
							exp_rec.key_upper, res_if.key_upper);
						fail_count++;
					end
					if (res_if.key_lower !== exp_rec.key_lower) begin
						$error("key_lower: expected %h, actual %h",
							exp_rec.key_lower, res_if.key_lower);
						fail_count++;
					end
					if (res_if.duration !== exp_rec.duration) begin
						$error("duration: expected %h, actual %h",
							exp_rec.duration, res_if.duration);
						fail_count++;
					end
				end
			end
			// In every third stretch of the run no new output stall is started.
			if (stall_left > 0) begin
				stall_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= 1'b1;
				if (((mon_cycles / 400) % 3) != 1 && $urandom_range(0, 99) < 25)
					stall_left = pick_gap();
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] k;
		int p;
		int n;
		int i;
		int mode;
		int entry_pct;
		int gap;
		cmd_t c;

		ev_if.valid = 1'b0;
		ev_if.command = CMD_ENTRY;
		ev_if.task_key = '0;
		ev_if.event_time = '0;
		res_if.ready = 1'b0;
		arst_n = 1'b0;
		fail_count = 0;
		n_events = 0;
		n_stored = 0;
		n_dup = 0;
		n_full = 0;
		n_miss = 0;
		n_checked = 0;
		clock_ns = {$urandom_range(0, 255), $urandom};
		for (i = 0; i < SLOTS; i++)
			open_valid[i] = 1'b0;

		// Directed words: extreme keys and times, duplicate entry, misses on near keys,
		// time going backwards and wrap of the duration.
		key_a = {$urandom, $urandom};
		add_word(CMD_ENTRY, '0, '0, 0, 1'b0);
		add_word(CMD_ENTRY, ALL_ONES, ALL_ONES, 0, 1'b0);
		add_word(CMD_ENTRY, '0, 64'd5, 0, 1'b0);
		add_word(CMD_EXIT, 64'hFFFF_FFFF_0000_0000, 64'd50, 0, 1'b0);
		add_word(CMD_EXIT, 64'h0000_0000_FFFF_FFFF, 64'd60, 0, 1'b0);
		add_word(CMD_EXIT, '0, 64'd100, 0, 1'b0);
		add_word(CMD_EXIT, '0, 64'd200, 0, 1'b0);
		add_word(CMD_EXIT, ALL_ONES, '0, 2, 1'b0);
		add_word(CMD_ENTRY, key_a, 64'd1000, 0, 1'b0);
		add_word(CMD_EXIT, key_a ^ 64'h8000_0000_0000_0000, 64'd1001, 0, 1'b0);
		add_word(CMD_EXIT, key_a ^ 64'h0000_0000_0000_0001, 64'd1002, 1, 1'b0);
		add_word(CMD_EXIT, key_a ^ 64'h0000_0001_0000_0000, 64'd1003, 0, 1'b0);
		add_word(CMD_EXIT, key_a, 64'd999, 0, 1'b0);
		add_word(CMD_ENTRY, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 0, 1'b0);
		add_word(CMD_ENTRY, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);
		add_word(CMD_EXIT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b0);
		add_word(CMD_EXIT, 64'hAAAA_AAAA_AAAA_AAAA, ALL_ONES, 3, 1'b0);
		add_word(CMD_EXIT, ALL_ONES, ALL_ONES, 0, 1'b0);

		// Random phases over a key pool renewed after each drain and noisy phase: fill past full,
		// drain, balanced traffic and noisy traffic. Each phase opens with a pause until all results are in.
		refill_pool();
		for (p = 0; p < PHASES; p++) begin
			mode = p % 4;
			case (mode)
				0: entry_pct = 80;
				1: entry_pct = 20;
				default: entry_pct = 50;
			endcase
			for (n = 0; n < PHASE_LEN; n++) begin
				gap = (p % 3 == 2) ? 0 : pick_gap();
				c = ($urandom_range(0, 99) < entry_pct) ? CMD_ENTRY : CMD_EXIT;
				k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
				// Exits of unknown keys: rare in the tidy phases, common in the noisy one.
				if (c == CMD_EXIT && $urandom_range(0, 99) < ((mode == 3) ? 40 : 5))
					k = {$urandom, $urandom};
				add_word(c, k, next_time(), gap, n == 0);
			end
			// Close every pool key before the pool is replaced.
			if (mode == 1 || mode == 3) begin
				for (i = 0; i < POOL_KEYS; i++)
					add_word(CMD_EXIT, key_pool[i], next_time(), pick_gap(), 1'b0);
				refill_pool();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_events.size() != 0 || ev_if.valid)
			@(posedge clk);
		while (expected_latencies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d events: %0d stored, %0d duplicate entries, %0d dropped on full table,",
			n_events, n_stored, n_dup, n_full);
		$display("%0d exit misses and %0d latency words checked.", n_miss, n_checked);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/eelt_pkg.sv
rtl/eelt_in_if.sv
rtl/eelt_out_if.sv
rtl/eelt_ram.sv
rtl/eelt_cam.sv
rtl/entry_exit_latency_table_unit.sv
tb/tb_entry_exit_latency_table_unit.sv
